/* rtl/core/bollinger_band_tracker_defines.svh */
// Assertion macros shared by the band tracker RTL.
`ifndef BOLLINGER_BAND_TRACKER_DEFINES_SVH
`define BOLLINGER_BAND_TRACKER_DEFINES_SVH

`ifndef SYNTH
// Condition must hold in the same cycle as the trigger.
`define BBA_ASSERT_IMPLY(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("bba assertion failed");
// Condition must hold in the cycle after the trigger.
`define BBA_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("bba assertion failed");
`else
`define BBA_ASSERT_IMPLY(label, trig, cond)
`define BBA_ASSERT_NEXT(label, trig, cond)
`endif

`endif

/* rtl/core/bba_pkg.sv */
package bba_pkg;

	// Defaults for the top-level parameters.
	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 24;

	// Fixed register and field widths.
	localparam int LEN_W      = 7;
	localparam int BW_W       = 12;
	localparam int BAND_W     = 30;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	// Shared divider and square root widths.
	localparam int DIV_W  = 64;
	localparam int ROOT_W = 32;

	// Register reset values and the ratio that stands for 1.0.
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd20;
	localparam logic [BW_W-1:0]  BW_RESET  = 12'd512;
	localparam logic [BW_W-1:0]  RATIO_ONE = 12'd256;

	// Band limits and the largest scaled deviation kept.
	localparam int BAND_MAX = 536870911;
	localparam int BAND_MIN = -536870912;
	localparam logic [30:0] SCALED_MAX = 31'd1073741822;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH    = 1'd1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_MDIV,
		ST_MEAN,
		ST_VAR,
		ST_VDRAIN,
		ST_ADIV,
		ST_SQRT,
		ST_MUL,
		ST_OUT
	} state_t;

endpackage

/* rtl/core/bba_ram.sv */
module bba_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/bba_div.sv */
module bba_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bba_pkg::DIV_W-1:0]      dividend,
	input  logic [bba_pkg::LEN_W-1:0]      divisor,
	output logic                           done,
	output logic [bba_pkg::DIV_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(bba_pkg::DIV_W);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [bba_pkg::LEN_W-1:0]    dsr_q;
	logic [bba_pkg::LEN_W-1:0]    rem_q;
	logic [bba_pkg::DIV_W-1:0]    quo_q;
	logic [bba_pkg::LEN_W:0]      rem_sh;
	logic [bba_pkg::LEN_W:0]      rem_sub;
	logic                         take;

	// One restoring step: bring in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh  = {rem_q, quo_q[bba_pkg::DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		take    = rem_sh >= {1'b0, dsr_q};
	end

	// Control: one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(bba_pkg::DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[bba_pkg::LEN_W-1:0] : rem_sh[bba_pkg::LEN_W-1:0];
			quo_q <= {quo_q[bba_pkg::DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/bba_sqrt.sv */
module bba_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bba_pkg::DIV_W-1:0]   operand,
	output logic                        done,
	output logic [bba_pkg::ROOT_W-1:0]  root
);

	localparam int CNT_W = $clog2(bba_pkg::ROOT_W);
	localparam int REM_W = bba_pkg::ROOT_W + 2;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [bba_pkg::DIV_W-1:0]   op_q;
	logic [REM_W-1:0]            rem_q;
	logic [bba_pkg::ROOT_W-1:0]  root_q;
	logic [REM_W+1:0]            rem_sh;
	logic [REM_W+1:0]            trial;
	logic [REM_W+1:0]            rem_sub;
	logic                        take;

	// One digit step: two operand bits in, one root bit out.
	always_comb begin
		rem_sh  = {rem_q, op_q[bba_pkg::DIV_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		take    = rem_sh >= trial;
	end

	// Control: one root bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(bba_pkg::ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder, root and operand shift.
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[bba_pkg::DIV_W-3:0], 2'b00};
			rem_q  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[bba_pkg::ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/core/bollinger_band_tracker.sv */
// Bollinger band tracker: takes one signed sample per transfer and returns one
// result per sample with the window mean and the bands at mean plus and minus
// the scaled population deviation. Until window_length samples have arrived the
// result carries valid_res low and zero bands. With a full window a bit-serial
// divider is used twice (mean, then mean square), the window is walked one
// entry per cycle through the sample RAM read port, and a digit-serial root
// unit takes the square root. The sample input is stalled while an item is
// being processed. Writing window_length clears the history.
`include "bollinger_band_tracker_defines.svh"

module bollinger_band_tracker #(
	parameter int WINDOW_MAX   = bba_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = bba_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 band_valid,
	input  logic                                 band_stall,
	output logic                                 valid_res,
	output logic signed [bba_pkg::BAND_W-1:0]    upper_band,
	output logic signed [SAMPLE_WIDTH-1:0]       middle_band,
	output logic signed [bba_pkg::BAND_W-1:0]    lower_band
);

	localparam int PW    = $clog2(WINDOW_MAX);
	localparam int SW    = SAMPLE_WIDTH;
	localparam int LW    = bba_pkg::LEN_W;
	localparam int SUM_W = SW + PW + 1;
	localparam int SQ_W  = 2 * SW + 2;
	localparam int SQX_W = (SQ_W > 64) ? SQ_W : 65;
	localparam int B_W   = ((SW > 31) ? SW : 31) + 2;
	localparam int PROD_W = bba_pkg::ROOT_W + bba_pkg::BW_W;
	localparam logic signed [B_W-1:0] BMAX = B_W'(bba_pkg::BAND_MAX);
	localparam logic signed [B_W-1:0] BMIN = B_W'(bba_pkg::BAND_MIN);

	bba_pkg::state_t state_q, state_nx;

	logic [LW-1:0]                   len_q;
	logic [bba_pkg::BW_W-1:0]        bw_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic [PW-1:0]                   wp_q;
	logic [LW-1:0]                   fill_q;
	logic signed [SW-1:0]            x_q;
	logic                            neg_q;
	logic                            full_q;
	logic signed [SW-1:0]            mean_q;
	logic [LW-1:0]                   k_q;
	logic [63:0]                     acc_q;
	logic [bba_pkg::ROOT_W-1:0]      dev_q;
	logic [30:0]                     scaled_q;
	logic                            rdv_q;
	logic                            av_s1;
	logic                            sv_s2;
	logic [SW:0]                     a_s1;
	logic [SQ_W-1:0]                 sq_s2;
	logic                            band_valid_q;
	logic                            valid_res_q;
	logic signed [bba_pkg::BAND_W-1:0] upper_q;
	logic signed [SW-1:0]            middle_q;
	logic signed [bba_pkg::BAND_W-1:0] lower_q;

	logic                            cfg_xfer;
	logic                            in_xfer;
	logic                            out_load;
	logic                            pipe_empty;
	logic [LW-1:0]                   len_sat;
	logic                            full_old;
	logic signed [SUM_W-1:0]         sum_nx;
	logic [LW-1:0]                   fill_nx;
	logic                            full_nx;
	logic [SUM_W-1:0]                mag_nx;
	logic [LW-1:0]                   back;
	logic [PW:0]                     idx_raw;
	logic [PW-1:0]                   raddr;
	logic [SW-1:0]                   rdata;
	logic signed [SW:0]              diff;
	logic [SW:0]                     diff_abs;
	logic [SQX_W-1:0]                sqx;
	logic [63:0]                     sq64;
	logic [64:0]                     acc_sum;
	logic [bba_pkg::BW_W-1:0]        ratio;
	logic [PROD_W-1:0]               prod;
	logic [PROD_W-9:0]               prod_sh;
	logic signed [B_W-1:0]           up_raw;
	logic signed [B_W-1:0]           lo_raw;
	logic signed [B_W-1:0]           up_cl;
	logic signed [B_W-1:0]           lo_cl;
	logic signed [SW-1:0]            mean_nx;
	logic                            div_start;
	logic                            div_done;
	logic                            sqrt_start;
	logic                            sqrt_done;
	logic [bba_pkg::DIV_W-1:0]       div_dividend;
	logic [bba_pkg::DIV_W-1:0]       div_quo;
	logic [bba_pkg::ROOT_W-1:0]      sqrt_root;

	// Handshakes; configuration takes priority over a sample.
	assign cfg_ready    = (state_q == bba_pkg::ST_IDLE);
	assign sample_stall = (state_q != bba_pkg::ST_IDLE) || cfg_valid;
	assign cfg_xfer     = cfg_valid && cfg_ready;
	assign in_xfer      = sample_valid && !sample_stall;
	assign out_load     = (state_q == bba_pkg::ST_OUT) && (!band_valid_q || !band_stall);
	assign pipe_empty   = !rdv_q && !av_s1 && !sv_s2;

	// Window length written as zero means one and saturates at the ring depth.
	always_comb begin
		len_sat = cfg_data[LW-1:0];
		if (len_sat == '0) begin
			len_sat = LW'(1);
		end else if (int'(len_sat) > WINDOW_MAX) begin
			len_sat = LW'(WINDOW_MAX);
		end
	end

	// Running sum update for the sample just taken.
	always_comb begin
		full_old = fill_q >= len_q;
		sum_nx   = sum_q + SUM_W'(x_q) - (full_old ? SUM_W'(signed'(rdata)) : '0);
		fill_nx  = full_old ? fill_q : fill_q + 1'b1;
		full_nx  = fill_nx >= len_q;
		mag_nx   = sum_nx[SUM_W-1] ? unsigned'(-sum_nx) : unsigned'(sum_nx);
		mean_nx  = neg_q ? -signed'(div_quo[SW-1:0]) : signed'(div_quo[SW-1:0]);
	end

	// Ring address that lies back entries behind the write pointer.
	always_comb begin
		back    = (state_q == bba_pkg::ST_VAR) ? k_q : len_q;
		idx_raw = {1'b0, wp_q} + (PW + 1)'(WINDOW_MAX) - (PW + 1)'(back);
		if (idx_raw >= (PW + 1)'(WINDOW_MAX)) begin
			idx_raw = idx_raw - (PW + 1)'(WINDOW_MAX);
		end
		raddr = idx_raw[PW-1:0];
	end

	// Squared difference and saturating accumulation.
	always_comb begin
		diff     = {rdata[SW-1], rdata} - {mean_q[SW-1], mean_q};
		diff_abs = diff[SW] ? unsigned'(-diff) : unsigned'(diff);
		sqx      = SQX_W'(sq_s2);
		sq64     = (|sqx[SQX_W-1:64]) ? '1 : sqx[63:0];
		acc_sum  = {1'b0, acc_q} + {1'b0, sq64};
	end

	// Band scaling and clamping.
	always_comb begin
		ratio   = (bw_q == '0) ? bba_pkg::RATIO_ONE : bw_q;
		prod    = PROD_W'(dev_q) * PROD_W'(ratio);
		prod_sh = prod[PROD_W-1:8];
		up_raw  = B_W'(mean_q) + B_W'({1'b0, scaled_q});
		lo_raw  = B_W'(mean_q) - B_W'({1'b0, scaled_q});
		up_cl   = (up_raw > BMAX) ? BMAX : ((up_raw < BMIN) ? BMIN : up_raw);
		lo_cl   = (lo_raw > BMAX) ? BMAX : ((lo_raw < BMIN) ? BMIN : lo_raw);
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bba_pkg::ST_IDLE:   if (in_xfer) state_nx = bba_pkg::ST_UPD;
			bba_pkg::ST_UPD:    state_nx = full_nx ? bba_pkg::ST_MDIV : bba_pkg::ST_OUT;
			bba_pkg::ST_MDIV:   if (div_done) state_nx = bba_pkg::ST_MEAN;
			bba_pkg::ST_MEAN:   state_nx = bba_pkg::ST_VAR;
			bba_pkg::ST_VAR:    if (k_q == len_q) state_nx = bba_pkg::ST_VDRAIN;
			bba_pkg::ST_VDRAIN: if (pipe_empty) state_nx = bba_pkg::ST_ADIV;
			bba_pkg::ST_ADIV:   if (div_done) state_nx = bba_pkg::ST_SQRT;
			bba_pkg::ST_SQRT:   if (sqrt_done) state_nx = bba_pkg::ST_MUL;
			bba_pkg::ST_MUL:    state_nx = bba_pkg::ST_OUT;
			bba_pkg::ST_OUT:    if (out_load) state_nx = bba_pkg::ST_IDLE;
			default:            state_nx = bba_pkg::ST_IDLE;
		endcase
	end

	// Unit starts and operand selection.
	always_comb begin
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		div_dividend = acc_q;
		case (state_q)
			bba_pkg::ST_UPD: begin
				div_start    = full_nx;
				div_dividend = bba_pkg::DIV_W'(mag_nx);
			end
			bba_pkg::ST_VDRAIN: div_start = pipe_empty;
			bba_pkg::ST_ADIV:   sqrt_start = div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Registers, history and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= bba_pkg::LEN_RESET;
			bw_q   <= bba_pkg::BW_RESET;
			sum_q  <= '0;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_xfer) begin
			case (cfg_index)
				bba_pkg::REG_WINDOW_LENGTH: begin
					len_q  <= len_sat;
					sum_q  <= '0;
					wp_q   <= '0;
					fill_q <= '0;
				end
				bba_pkg::REG_BAND_WIDTH: bw_q <= cfg_data[bba_pkg::BW_W-1:0];
				default: ;
			endcase
		end else if (state_q == bba_pkg::ST_UPD) begin
			sum_q  <= sum_nx;
			fill_q <= fill_nx;
			wp_q   <= (wp_q == PW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	// Variance walk pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q <= 1'b0;
			av_s1 <= 1'b0;
			sv_s2 <= 1'b0;
		end else begin
			rdv_q <= (state_q == bba_pkg::ST_VAR);
			av_s1 <= rdv_q;
			sv_s2 <= av_s1;
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= sample;
		end
		if (state_q == bba_pkg::ST_UPD) begin
			neg_q  <= sum_nx[SUM_W-1];
			full_q <= full_nx;
		end
		if (state_q == bba_pkg::ST_MEAN) begin
			mean_q <= mean_nx;
			k_q    <= LW'(1);
			acc_q  <= '0;
		end else begin
			if (state_q == bba_pkg::ST_VAR) begin
				k_q <= k_q + 1'b1;
			end
			if (sv_s2) begin
				acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
			end
		end
		if (rdv_q) begin
			a_s1 <= diff_abs;
		end
		if (av_s1) begin
			sq_s2 <= SQ_W'(a_s1) * SQ_W'(a_s1);
		end
		if (state_q == bba_pkg::ST_SQRT && sqrt_done) begin
			dev_q <= sqrt_root;
		end
		if (state_q == bba_pkg::ST_MUL) begin
			scaled_q <= (prod_sh > (PROD_W - 8)'(bba_pkg::SCALED_MAX)) ?
				bba_pkg::SCALED_MAX : prod_sh[30:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_valid_q <= 1'b0;
		end else if (out_load) begin
			band_valid_q <= 1'b1;
		end else if (!band_stall) begin
			band_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			valid_res_q <= full_q;
			upper_q     <= full_q ? up_cl[bba_pkg::BAND_W-1:0] : '0;
			middle_q    <= full_q ? mean_q : '0;
			lower_q     <= full_q ? lo_cl[bba_pkg::BAND_W-1:0] : '0;
		end
	end

	assign band_valid  = band_valid_q;
	assign valid_res   = valid_res_q;
	assign upper_band  = upper_q;
	assign middle_band = middle_q;
	assign lower_band  = lower_q;

	// Sample ring.
	bba_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (state_q == bba_pkg::ST_UPD),
		.waddr (wp_q),
		.wdata (x_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared divider for the mean and the mean square.
	bba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Deviation root.
	bba_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (div_quo),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	`BBA_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_q <= len_q)
	`BBA_ASSERT_NEXT(a_take_update, in_xfer, state_q == bba_pkg::ST_UPD)
	`BBA_ASSERT_IMPLY(a_div_owner, div_done,
		state_q == bba_pkg::ST_MDIV || state_q == bba_pkg::ST_ADIV)
	`BBA_ASSERT_IMPLY(a_full_result, band_valid_q && valid_res_q, fill_q == len_q)

endmodule

/* sim/testbench.sv */
module testbench;

	// One band result as the block presents it.
	typedef struct {
		logic                              ok;
		logic signed [bba_pkg::BAND_W-1:0] upper;
		logic signed [23:0]                middle;
		logic signed [bba_pkg::BAND_W-1:0] lower;
	} band_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [23:0] sample = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bba_pkg::CFG_IDX_W-1:0] cfg_index = bba_pkg::REG_WINDOW_LENGTH;
	logic [bba_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic band_valid;
	logic band_stall = 1'b0;
	logic valid_res;
	logic signed [bba_pkg::BAND_W-1:0] upper_band;
	logic signed [23:0] middle_band;
	logic signed [bba_pkg::BAND_W-1:0] lower_band;

	// Predictor state: sample ring, running sum and register copies.
	longint ring [64];
	longint win_sum;
	int unsigned wr_ptr, fill, win_len, bw_ratio;

	logic signed [23:0] pending_samples [$];
	band_t expected_bands [$];
	bit steady = 1'b0;
	int errors = 0;
	int n_samples = 0;
	int n_bands = 0;
	int n_writes = 0;

	bollinger_band_tracker u_top (.*);

	always #5 clk = ~clk;

	function automatic void clear_ring();
		foreach (ring[i]) ring[i] = 0;
		win_sum = 0;
		wr_ptr = 0;
		fill = 0;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint clamp30(longint v);
		if (v > bba_pkg::BAND_MAX) return bba_pkg::BAND_MAX;
		if (v < bba_pkg::BAND_MIN) return bba_pkg::BAND_MIN;
		return v;
	endfunction

	// Advance the window by one sample and compute the bands it yields.
	function automatic band_t next_bands(logic signed [23:0] s);
		band_t r;
		longint x = s;
		longint mean, d;
		longint unsigned acc = 0, a, sq, dev, scaled, ratio;
		if (fill >= win_len) win_sum -= ring[(wr_ptr + 64 - win_len) % 64];
		win_sum += x;
		ring[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1) % 64;
		if (fill < win_len) fill++;
		r = '{1'b0, '0, '0, '0};
		if (fill < win_len) return r;
		mean = win_sum / longint'(win_len);
		for (int k = 1; k <= win_len; k++) begin
			d = ring[(wr_ptr + 64 - k) % 64] - mean;
			a = d < 0 ? -d : d;
			sq = a * a;
			if (a != 0 && sq / a != a) sq = '1;
			if (acc > ~64'd0 - sq) acc = '1;
			else acc += sq;
		end
		ratio = bw_ratio ? bw_ratio : 256;
		dev = floor_sqrt(acc / win_len);
		scaled = (dev * ratio) >> 8;
		if (scaled > 64'd1073741822) scaled = 64'd1073741822;
		r.ok = 1'b1;
		r.upper = bba_pkg::BAND_W'(clamp30(mean + longint'(scaled)));
		r.middle = 24'(mean);
		r.lower = bba_pkg::BAND_W'(clamp30(mean - longint'(scaled)));
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch on band %0d: %s got %0d expected %0d", n_bands, what, got, want);
		errors++;
	endtask

	// Driver: presents queued samples and predicts on each transfer.
	always @(posedge clk) begin
		logic taken;
		taken = sample_valid && !sample_stall;
		if (taken) begin
			expected_bands.insert(expected_bands.size(), next_bands(sample));
			n_samples++;
		end
		if (arst_n && (!sample_valid || taken)) begin
			if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
				sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stall and comparison with the oldest prediction.
	always @(posedge clk) begin
		band_t e;
		if (band_valid && !band_stall) begin
			if (expected_bands.size() == 0) begin
				$display("band result with no sample waiting for it");
				errors++;
			end else begin
				e = expected_bands.pop_front();
				if (valid_res !== e.ok) report("valid_res", valid_res, e.ok);
				if (upper_band !== e.upper) report("upper_band", upper_band, e.upper);
				if (middle_band !== e.middle) report("middle_band", middle_band, e.middle);
				if (lower_band !== e.lower) report("lower_band", lower_band, e.lower);
			end
			n_bands++;
		end
		band_stall <= arst_n && !steady && $urandom_range(99) < 20;
	end

	// Register write through the configuration channel, mirrored in the predictor.
	task automatic write_reg(logic [bba_pkg::CFG_IDX_W-1:0] idx,
		logic [bba_pkg::CFG_DATA_W-1:0] val);
		int unsigned v;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		if (idx == bba_pkg::REG_WINDOW_LENGTH) begin
			v = val & 12'h7F;
			if (v == 0) v = 1;
			if (v > 64) v = 64;
			win_len = v;
			clear_ring();
		end else begin
			bw_ratio = val;
		end
	endtask

	// Let the block finish all outstanding transfers.
	task automatic drain();
		while (pending_samples.size() > 0 || sample_valid || expected_bands.size() > 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample(int base, int spread);
		case ($urandom_range(9))
			0: return 24'($urandom);
			1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return 24'(base + $signed($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	// Stimulus: directed extremes at reset settings, then phases of settings.
	initial begin
		int lens [10] = '{1, 0, 64, 100, 12'h85, 2, 7, 20, 33, 64};
		int bws [10] = '{0, 4095, 256, 1, 512, 0, 4095, 100, 300, 2048};
		int base, spread, count;
		win_len = 20;
		bw_ratio = 512;
		clear_ring();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		pending_samples = '{24'sh7FFFFF, 24'sh800000, 24'sd0, -24'sd1, 24'sd1,
			24'sh555555, 24'shAAAAAA};
		repeat (18) pending_samples.insert(pending_samples.size(),
			($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000);
		drain();
		for (int p = 0; p < 14; p++) begin
			steady = (p == 5);
			write_reg(bba_pkg::REG_WINDOW_LENGTH,
				bba_pkg::CFG_DATA_W'(p < 10 ? lens[p] : $urandom_range(1, 64)));
			write_reg(bba_pkg::REG_BAND_WIDTH,
				bba_pkg::CFG_DATA_W'(p < 10 ? bws[p] : $urandom_range(4095)));
			base = $signed($urandom) >>> 9;
			spread = 1 << $urandom_range(23);
			count = win_len + 32 + $urandom_range(40);
			for (int i = 0; i < count; i++)
				pending_samples.insert(pending_samples.size(), rand_sample(base, spread));
			drain();
		end
		steady = 1'b0;
		$display("covered %0d samples and %0d band results", n_samples, n_bands);
		$display("across %0d register writes, window lengths 1 to 64", n_writes);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end
endmodule
